// ===== hw/rtl/wetm_pkg.sv =====
// ----------------------------------------------------------------------------
// wetm_pkg
// Shared types, constants and register indexes of the windowed event monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package wetm_pkg;

	localparam int WINDOWS_DEF    = 6;
	localparam int RING_DEPTH_DEF = 32;
	localparam int TIME_W         = 32;
	localparam int THR_W          = 6;
	localparam int INTV_W         = 20;
	localparam int MASK_W         = 6;
	localparam int CFG_AW         = 5;

	// register indexes
	typedef enum logic [2:0] {
		REG_DURATION  = 3'd0,
		REG_SLOW_THR  = 3'd1,
		REG_SLOW_INTV = 3'd2,
		REG_FAST_THR  = 3'd3,
		REG_FAST_INTV = 3'd4,
		REG_FAST_MASK = 3'd5,
		REG_EN_MASK   = 3'd6,
		REG_COOLDOWN  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] window_duration;
		logic [THR_W-1:0]  slow_threshold;
		logic [INTV_W-1:0] slow_interval;
		logic [THR_W-1:0]  fast_threshold;
		logic [INTV_W-1:0] fast_interval;
		logic [MASK_W-1:0] fast_window_mask;
		logic [MASK_W-1:0] enable_mask;
		logic [TIME_W-1:0] cooldown_length;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COOL,
		ST_RD,
		ST_WAITRD,
		ST_MUL,
		ST_READY,
		ST_EXPIRE,
		ST_POPRD,
		ST_PUSH,
		ST_FIRECHK,
		ST_DONE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic cool_chk;   // evaluate cooldown
		logic win_clr;    // window index to zero
		logic win_inc;    // next window
		logic mul;        // register interval * count
		logic pop;        // drop oldest
		logic push;       // write now
		logic fire_chk;   // update reason bit
		logic finish;     // commit firing, build result
		logic out_cool;   // build cooldown result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_cool;
		logic not_ready;
		logic want_hit;
		logic cnt_zero;
		logic expired;
		logic last_win;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wetm_ram.sv =====
// ----------------------------------------------------------------------------
// wetm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module wetm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, and registered read of the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wetm_regs.sv =====
// ----------------------------------------------------------------------------
// wetm_regs
// APB register file for the monitor configuration.
// ----------------------------------------------------------------------------
`default_nettype none
module wetm_regs (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [wetm_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output wetm_pkg::cfg_t             cfg
);
	import wetm_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_duration  <= 32'd60000;
			cfg_q.slow_threshold   <= 6'd6;
			cfg_q.slow_interval    <= 20'd10000;
			cfg_q.fast_threshold   <= 6'd30;
			cfg_q.fast_interval    <= 20'd1000;
			cfg_q.fast_window_mask <= 6'd4;
			cfg_q.enable_mask      <= 6'd63;
			cfg_q.cooldown_length  <= 32'd5000;
		end else if (wr) begin
			unique case (idx)
				REG_DURATION:  cfg_q.window_duration  <= pwdata;
				REG_SLOW_THR:  cfg_q.slow_threshold   <= pwdata[THR_W-1:0];
				REG_SLOW_INTV: cfg_q.slow_interval    <= pwdata[INTV_W-1:0];
				REG_FAST_THR:  cfg_q.fast_threshold   <= pwdata[THR_W-1:0];
				REG_FAST_INTV: cfg_q.fast_interval    <= pwdata[INTV_W-1:0];
				REG_FAST_MASK: cfg_q.fast_window_mask <= pwdata[MASK_W-1:0];
				REG_EN_MASK:   cfg_q.enable_mask      <= pwdata[MASK_W-1:0];
				REG_COOLDOWN:  cfg_q.cooldown_length  <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_DURATION:  prdata = cfg_q.window_duration;
			REG_SLOW_THR:  prdata = {26'd0, cfg_q.slow_threshold};
			REG_SLOW_INTV: prdata = {12'd0, cfg_q.slow_interval};
			REG_FAST_THR:  prdata = {26'd0, cfg_q.fast_threshold};
			REG_FAST_INTV: prdata = {12'd0, cfg_q.fast_interval};
			REG_FAST_MASK: prdata = {26'd0, cfg_q.fast_window_mask};
			REG_EN_MASK:   prdata = {26'd0, cfg_q.enable_mask};
			REG_COOLDOWN:  prdata = cfg_q.cooldown_length;
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wetm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wetm_ctrl
// Sequencer: walks the windows one at a time for each tick not ignored for cooldown.
// ----------------------------------------------------------------------------
`default_nettype none
module wetm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire wetm_pkg::sts_t sts,
	output wetm_pkg::cmd_t      cmd
);
	import wetm_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COOL;
				end
			end
			ST_COOL: begin
				cmd.win_clr = 1'b1;
				if (sts.in_cool) begin
					cmd.out_cool = 1'b1;
					state_d      = ST_OUT;
				end else begin
					cmd.cool_chk = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_WAITRD;
			end
			ST_WAITRD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_READY;
			end
			ST_READY: begin
				if (sts.want_hit && !sts.not_ready) begin
					state_d = ST_EXPIRE;
				end else begin
					state_d = ST_FIRECHK;
				end
			end
			ST_EXPIRE: begin
				if (!sts.cnt_zero && sts.expired) begin
					cmd.pop = 1'b1;
					state_d = ST_POPRD;
				end else begin
					state_d = ST_PUSH;
				end
			end
			// read the new oldest entry, spacing check is not repeated
			ST_POPRD: begin
				state_d = ST_EXPIRE;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_FIRECHK;
			end
			ST_FIRECHK: begin
				cmd.fire_chk = 1'b1;
				if (sts.last_win) begin
					state_d = ST_DONE;
				end else begin
					cmd.win_inc = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wetm_dp.sv =====
// ----------------------------------------------------------------------------
// wetm_dp
// Datapath: ring pointers, hit time memory, compares and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module wetm_dp #(
	parameter int WINDOWS    = wetm_pkg::WINDOWS_DEF,
	parameter int RING_DEPTH = wetm_pkg::RING_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wetm_pkg::cfg_t               cfg,
	input  wire wetm_pkg::cmd_t               cmd,
	output wetm_pkg::sts_t                    sts,
	input  wire logic [wetm_pkg::TIME_W-1:0]  time_in,
	input  wire logic [wetm_pkg::MASK_W-1:0]  hit_flags,
	output logic                              emit,
	output logic [wetm_pkg::MASK_W-1:0]       reason_mask,
	output logic                              in_cooldown
);
	import wetm_pkg::*;

	localparam int WI_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int DEPTH = WINDOWS * RING_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [TIME_W-1:0]  now_q;
	logic [MASK_W-1:0]  hits_q;
	logic [PTR_W-1:0]   head_q [WINDOWS];
	logic [CNT_W-1:0]   count_q [WINDOWS];
	logic [TIME_W-1:0]  cool_start_q;
	logic               cool_act_q;
	logic [WI_W-1:0]    win_q;
	logic [WINDOWS-1:0] reason_q;
	logic [TIME_W+CNT_W-1:0] prod_q;
	logic               emit_q, cool_out_q;
	logic [MASK_W-1:0]  rmask_q;

	logic [TIME_W-1:0]  oldest;
	logic [PTR_W-1:0]   head;
	logic [CNT_W-1:0]   cnt;
	logic               fast, en, hit;
	logic [THR_W-1:0]   thr_raw;
	logic [CNT_W-1:0]   thr;
	logic [INTV_W-1:0]  intv;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [PTR_W:0]     slot_sum;
	logic [PTR_W-1:0]   slot;
	logic [PTR_W-1:0]   head_nx;
	logic [CNT_W-1:0]   cnt_push;
	logic [TIME_W-1:0]  elapsed;

	// current window selection
	always_comb begin
		head = head_q[win_q];
		cnt  = count_q[win_q];
		fast = (32'(win_q) < MASK_W) && cfg.fast_window_mask[win_q];
		en   = (32'(win_q) < MASK_W) && cfg.enable_mask[win_q];
		hit  = (32'(win_q) < MASK_W) && hits_q[win_q];
		thr_raw = fast ? cfg.fast_threshold : cfg.slow_threshold;
		intv    = fast ? cfg.fast_interval : cfg.slow_interval;
		if (thr_raw == '0) begin
			thr = CNT_W'(1);
		end else if (32'(thr_raw) > RING_DEPTH) begin
			thr = CNT_W'(RING_DEPTH);
		end else begin
			thr = CNT_W'(thr_raw);
		end
	end

	// ring slot: head plus count on push, head on read
	always_comb begin
		head_nx  = (32'(head) == RING_DEPTH - 1) ? '0 : head + PTR_W'(1);
		cnt_push = cnt;
		if (32'(cnt) >= RING_DEPTH) begin
			cnt_push = CNT_W'(RING_DEPTH - 1);
		end
		if (cmd.push) begin
			if (32'(cnt) >= RING_DEPTH) begin
				slot_sum = {1'b0, head_nx} + (PTR_W+1)'(cnt_push);
			end else begin
				slot_sum = {1'b0, head} + (PTR_W+1)'(cnt);
			end
		end else begin
			slot_sum = {1'b0, head};
		end
		if (32'(slot_sum) >= RING_DEPTH) begin
			slot = PTR_W'(32'(slot_sum) - RING_DEPTH);
		end else begin
			slot = PTR_W'(slot_sum);
		end
		ram_we   = cmd.push;
		ram_addr = AW'(32'(win_q) * RING_DEPTH + 32'(slot));
	end

	wetm_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (now_q),
		.rdata (oldest)
	);

	// status to controller
	always_comb begin
		elapsed       = now_q - cool_start_q;
		sts.in_cool   = cool_act_q && (elapsed < cfg.cooldown_length);
		sts.cnt_zero  = (cnt == '0);
		sts.not_ready = (cnt != '0) &&
			(({1'b0, prod_q} + (TIME_W+CNT_W+1)'(oldest)) > (TIME_W+CNT_W+1)'(now_q));
		sts.want_hit  = en && hit;
		sts.expired   = ({1'b0, oldest} + {1'b0, cfg.window_duration}) < {1'b0, now_q};
		sts.last_win  = (32'(win_q) == WINDOWS - 1);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q  <= time_in;
			hits_q <= hit_flags;
		end
		if (cmd.mul) begin
			prod_q <= (TIME_W+CNT_W)'({{CNT_W{1'b0}}, intv} * {{INTV_W{1'b0}}, cnt});
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOWS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			cool_start_q <= '0;
			cool_act_q   <= 1'b0;
			win_q        <= '0;
			reason_q     <= '0;
			emit_q       <= 1'b0;
			rmask_q      <= '0;
			cool_out_q   <= 1'b0;
		end else begin
			if (cmd.win_clr) begin
				win_q    <= '0;
				reason_q <= '0;
			end else if (cmd.win_inc) begin
				win_q <= win_q + WI_W'(1);
			end
			if (cmd.cool_chk) begin
				cool_act_q <= 1'b0;
			end
			if (cmd.pop) begin
				head_q[win_q]  <= head_nx;
				count_q[win_q] <= cnt - CNT_W'(1);
			end
			if (cmd.push) begin
				if (32'(cnt) >= RING_DEPTH) begin
					head_q[win_q] <= head_nx;
				end
				count_q[win_q] <= cnt_push + CNT_W'(1);
			end
			if (cmd.fire_chk && (cnt >= thr)) begin
				reason_q[win_q] <= 1'b1;
			end
			if (cmd.out_cool) begin
				emit_q     <= 1'b0;
				rmask_q    <= '0;
				cool_out_q <= 1'b1;
			end
			if (cmd.finish) begin
				emit_q     <= (reason_q != '0);
				cool_out_q <= 1'b0;
				for (int i = 0; i < MASK_W; i++) begin
					rmask_q[i] <= (i < WINDOWS) ? reason_q[i % WINDOWS] : 1'b0;
				end
				if (reason_q != '0) begin
					for (int i = 0; i < WINDOWS; i++) begin
						head_q[i]  <= '0;
						count_q[i] <= '0;
					end
					cool_start_q <= now_q;
					cool_act_q   <= 1'b1;
				end
			end
		end
	end

	assign emit        = emit_q;
	assign reason_mask = rmask_q;
	assign in_cooldown = cool_out_q;

	// checks
	a_emit_mask: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q == (rmask_q != '0)) else $error("emit and reason mask disagree");
	a_cool_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cool_out_q && emit_q)) else $error("cooldown result with emit");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt) <= RING_DEPTH) else $error("ring count overflow");
	a_fire_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && reason_q != '0) |=> cool_act_q && count_q[0] == '0)
		else $error("firing did not clear rings");
endmodule
`default_nettype wire

// ===== hw/rtl/windowed_event_threshold_monitor_core.sv =====
// ----------------------------------------------------------------------------
// windowed_event_threshold_monitor_core
// Sliding window hit counter with per-window thresholds and a cooldown.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick item: tdata = tick time in ms, tuser = hit_flags.
//   m_axis returns one result per tick: tdata = reason_mask,
//   tuser = {in_cooldown, emit}.
//   The APB port holds the eight configuration registers at 4*i.
// Sequence:
//   one tick at a time. A tick ignored for cooldown goes from COOL to the
//   result; otherwise each window runs RD, WAITRD, MUL, READY and FIRECHK,
//   plus EXPIRE and PUSH if it records a hit and EXPIRE and POPRD per
//   expired entry dropped, over the single ram port that walks each ring in
//   turn. The next tick can be accepted in the cycle after the result is taken.
// Reset:
//   all rings empty, cooldown inactive, registers at their default values.
//   The hit time memory is not cleared; only filled slots are ever used.
// Stall:
//   the result is held in m_axis until taken; s_axis_tready stays low until
//   then.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_event_threshold_monitor_core #(
	parameter int WINDOWS    = wetm_pkg::WINDOWS_DEF,
	parameter int RING_DEPTH = wetm_pkg::RING_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // time in ms
	input  wire logic [5:0]  s_axis_tuser,   // hit_flags
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // reason_mask, zero pad
	output logic [1:0]       m_axis_tuser,   // emit, in_cooldown
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [wetm_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import wetm_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic emit, in_cool;
	logic [MASK_W-1:0] rmask;

	wetm_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	wetm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts(sts), .cmd(cmd)
	);

	wetm_dp #(.WINDOWS(WINDOWS), .RING_DEPTH(RING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .sts(sts),
		.time_in(s_axis_tdata), .hit_flags(s_axis_tuser),
		.emit(emit), .reason_mask(rmask), .in_cooldown(in_cool)
	);

	assign m_axis_tdata = {2'b00, rmask};
	assign m_axis_tuser = {in_cool, emit};
endmodule
`default_nettype wire

// ===== verif/windowed_event_threshold_monitor_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_event_threshold_monitor_core_tb
// Self-checking bench: tick items go in on s_axis and each result is checked
// against a cycle-free predictor of the window rings and the cooldown.
// Registers are rewritten over several phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_event_threshold_monitor_core_tb;
	import wetm_pkg::*;

	localparam int NWIN  = 6;
	localparam int DEPTH = 32;

	typedef struct {
		logic [31:0] stamp;
		logic [5:0]  hits;
	} tick_t;

	typedef struct {
		logic       emit;
		logic [5:0] reasons;
		logic       cooling;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // time in ms
	logic [5:0]  s_axis_tuser;   // hit_flags
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // reason_mask, zero pad
	logic [1:0]  m_axis_tuser;   // emit, in_cooldown
	logic        psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	windowed_event_threshold_monitor_core DUT (.*);

	always #2 clk = ~clk;

	// predictor state and register copy
	logic [31:0] cfg_regs [8];
	logic [31:0] hit_times [NWIN][DEPTH];
	int          ring_head [NWIN];
	int          ring_count [NWIN];
	logic [31:0] cool_start;
	bit          cool_active;

	tick_t    tick_q [$];
	verdict_t verdict_q [$];
	int       err_count = 0;
	bit       calm = 0;
	bit       pause_ticks = 0;
	bit       hold_start = 0;
	int       hold_left = 0;
	int       send_gap = 0;
	int       stall_left = 0;
	logic [31:0] tick_clock = 0;

	function automatic verdict_t score_tick(tick_t t);
		verdict_t v;
		logic [5:0]  fired;
		logic [31:0] thr, intv, oldest;
		bit fast, ready;
		fired = '0;
		v = '{1'b0, 6'd0, 1'b0};
		if (cool_active) begin
			if (t.stamp - cool_start < cfg_regs[REG_COOLDOWN]) begin
				v.cooling = 1'b1;
				return v;
			end
			cool_active = 0;
		end
		for (int w = 0; w < NWIN; w++) begin
			fast = cfg_regs[REG_FAST_MASK][w];
			thr  = fast ? cfg_regs[REG_FAST_THR] : cfg_regs[REG_SLOW_THR];
			intv = fast ? cfg_regs[REG_FAST_INTV] : cfg_regs[REG_SLOW_INTV];
			if (thr == 0) thr = 1;
			if (thr > DEPTH) thr = DEPTH;
			ready = 1;
			if (ring_count[w] != 0) begin
				oldest = hit_times[w][ring_head[w]];
				if (64'(oldest) + 64'(intv) * 64'(ring_count[w]) > 64'(t.stamp))
					ready = 0;
			end
			if (ready && cfg_regs[REG_EN_MASK][w] && t.hits[w]) begin
				// expire aged entries, then store now
				while (ring_count[w] != 0 && 64'(hit_times[w][ring_head[w]])
						+ 64'(cfg_regs[REG_DURATION]) < 64'(t.stamp)) begin
					ring_head[w] = (ring_head[w] + 1) % DEPTH;
					ring_count[w]--;
				end
				if (ring_count[w] >= DEPTH) begin
					ring_head[w] = (ring_head[w] + 1) % DEPTH;
					ring_count[w] = DEPTH - 1;
				end
				hit_times[w][(ring_head[w] + ring_count[w]) % DEPTH] = t.stamp;
				ring_count[w]++;
			end
			if (ring_count[w] >= thr) fired[w] = 1'b1;
		end
		if (fired != 0) begin
			for (int w = 0; w < NWIN; w++) begin
				ring_head[w] = 0;
				ring_count[w] = 0;
			end
			cool_start = t.stamp;
			cool_active = 1;
		end
		v.emit = (fired != 0);
		v.reasons = fired;
		return v;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	// driver: one item in flight on s_axis, predicted when accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				verdict_q = {verdict_q, score_tick(tick_t'{s_axis_tdata, s_axis_tuser})};
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() != 0 && !pause_ticks) begin
					tick_t t;
					t = tick_q.pop_front();
					s_axis_tdata <= t.stamp;
					s_axis_tuser <= t.hits;
					s_axis_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 13);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start) hold_left <= 400;
		else if (hold_left > 0) hold_left <= hold_left - 1;
	end

	// monitor: check each result item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected item", 32'({m_axis_tuser, m_axis_tdata}),
						32'd0);
				end else begin
					verdict_t v;
					v = verdict_q.pop_front();
					if (m_axis_tdata[5:0] !== v.reasons)
						report_mismatch("reason_mask", 32'(m_axis_tdata[5:0]),
							32'(v.reasons));
					if (m_axis_tuser[0] !== v.emit)
						report_mismatch("emit", 32'(m_axis_tuser[0]), 32'(v.emit));
					if (m_axis_tuser[1] !== v.cooling)
						report_mismatch("in_cooldown", 32'(m_axis_tuser[1]), 32'(v.cooling));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (hold_left == 0);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DURATION, REG_COOLDOWN: cfg_regs[idx] = value;
			REG_SLOW_INTV, REG_FAST_INTV: cfg_regs[idx] = value & 32'hFFFFF;
			default: cfg_regs[idx] = value & 32'h3F;
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (tick_q.size() != 0 || verdict_q.size() != 0 || s_axis_tvalid);
	endtask

	task automatic queue_tick(logic [31:0] stamp, logic [5:0] hits);
		tick_q = {tick_q, tick_t'{stamp, hits}};
	endtask

	// random ticks with mostly small time steps, sometimes large jumps
	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: tick_clock = $urandom;
				1, 2: tick_clock += $urandom_range(0, 5000);
				default: tick_clock += $urandom_range(0, 400);
			endcase
			queue_tick(tick_clock, 6'($urandom_range(0, 63)));
		end
	endtask

	function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi,
			logic [31:0] mid_lo, logic [31:0] mid_hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(mid_hi, mid_lo);
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		m_axis_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_regs = '{60000, 6, 10000, 30, 1000, 4, 63, 5000};
		for (int w = 0; w < NWIN; w++) begin
			ring_head[w] = 0;
			ring_count[w] = 0;
		end
		cool_start = 0;
		cool_active = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: slow windows fill at 10 s spacing and fire
		for (int i = 0; i <= 6; i++) queue_tick(i * 10000, 6'h3F);
		queue_tick(62000, 6'h3F);           // too soon for the slow windows
		queue_tick(65000, 6'h3F);           // too soon for the slow windows
		queue_tick(65000, 6'h3F);           // too soon for the slow windows, not counted there
		queue_tick(200000, 6'h00);
		queue_tick(32'hFFFF_FFF0, 6'h15);
		queue_tick(32'hFFFF_FFFF, 6'h2A);
		wait_drained();

		// lowered threshold fires on a tick with no hits; wrapped cooldown
		write_reg(REG_SLOW_THR, 0);
		write_reg(REG_FAST_THR, 63);
		queue_tick(32'hFFFF_FFFF, 6'h00);
		queue_tick(32'h0000_0100, 6'h3F);   // elapsed wraps, still cooling
		queue_tick(32'h0000_2000, 6'h3F);
		queue_tick(32'h0000_3000, 6'h00);
		wait_drained();

		// eight stores per ring, short of full: fast windows, no spacing, never fire
		write_reg(REG_FAST_MASK, 63);
		write_reg(REG_FAST_INTV, 0);
		write_reg(REG_FAST_THR, 63);
		write_reg(REG_DURATION, 32'hFFFF_FFFF);
		for (int i = 0; i < 8; i++) queue_tick(32'h4000 + i, 6'h3F);
		wait_drained();
		tick_clock = 32'h5000;

		// random phases over register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_DURATION, pick(0, 32'hFFFF_FFFF, 200, 20000));
			write_reg(REG_SLOW_THR, pick(1, 32, 1, 8));
			write_reg(REG_SLOW_INTV, pick(0, 32'hFFFFF, 0, 300));
			write_reg(REG_FAST_THR, pick(0, 63, 1, 12));
			write_reg(REG_FAST_INTV, pick(0, 32'hF4240, 0, 100));
			write_reg(REG_FAST_MASK, $urandom_range(0, 63));
			write_reg(REG_EN_MASK, (ph == 0) ? 0 : (ph == 1) ? 63 : $urandom_range(0, 63));
			write_reg(REG_COOLDOWN, (ph == 2) ? 32'hFFFF_FFFF : (ph == 3) ? 0 :
				$urandom_range(0, 3000));
			if (ph == 7) calm = 1;
			queue_random(53);
			if (ph == 4) begin
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			if (ph == 5) begin
				repeat (20) @(posedge clk);
				pause_ticks = 1;
				while (verdict_q.size() != 0 || s_axis_tvalid) @(posedge clk);
				pause_ticks = 0;
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
